// ----- hdl/tcw_pkg.sv -----
// Shared types, constants and helper functions for the text console writer.
// Used by tcw_screen_ram, tcw_ctrl and text_console_writer; depends on nothing.
package tcw_pkg;

	// Screen geometry and tab spacing.
	localparam int SCREEN_COLS  = 80;
	localparam int SCREEN_ROWS  = 25;
	localparam int TAB_STOP     = 8;
	localparam int SCROLL_LINES = 1;

	localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
	localparam int SHIFT_RAW  = SCROLL_LINES * SCREEN_COLS;
	localparam int SHIFT      = (SHIFT_RAW > CELL_COUNT) ? CELL_COUNT : SHIFT_RAW;
	localparam int MOVE_COUNT = CELL_COUNT - SHIFT;

	// Widths of the stored and internal values.
	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 4;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);
	localparam int ROW_W  = $clog2(SCREEN_ROWS + 2);
	localparam int COL_W  = $clog2(SCREEN_COLS);

	// Widths of the port fields.
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;

	// Commands and character codes.
	localparam logic CMD_PRINT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

	// Register indexes of the configuration port.
	localparam logic CFG_SCROLL_FG = 1'b0;
	localparam logic CFG_SCROLL_BG = 1'b1;

	localparam logic [COLOR_W-1:0] RESET_FG = 4'd7;
	localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

	// One input word.
	typedef struct packed {
		logic                    command;
		logic [CHAR_W-1:0]       char_code;
		logic [COLOR_W-1:0]      fg_color;
		logic [COLOR_W-1:0]      bg_color;
		logic [ROW_OUT_W-1:0]    read_row;
		logic [COL_OUT_W-1:0]    read_col;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [ROW_OUT_W-1:0] caret_row;
		logic [COL_OUT_W-1:0] caret_col;
		logic [CELL_W-1:0]    cell_value;
	} result_t;

	// Write and read requests toward the screen store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// Pack a character and its colors into one cell.
	function automatic logic [CELL_W-1:0] make_cell(
		input logic [CHAR_W-1:0]  ch,
		input logic [COLOR_W-1:0] fg,
		input logic [COLOR_W-1:0] bg
	);
		make_cell = {bg, fg, ch};
	endfunction

	// Linear cell address; the multiply by the column count is a constant shift-add.
	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col
	);
		cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col));
	endfunction

	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CH_BLANK};

endpackage

// ----- hdl/tcw_screen_ram.sv -----
// Screen store of the text console writer: one write port, one registered read port.
// Depends on tcw_pkg for the cell and address widths and the request structs.
module tcw_screen_ram (
	input  logic                           clk,
	input  tcw_pkg::ram_wr_t               wr,
	input  tcw_pkg::ram_rd_t               rd,
	output logic [tcw_pkg::CELL_W-1:0]     rd_data
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [CELL_COUNT];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ----- hdl/tcw_ctrl.sv -----
// Sequencer of the text console writer: caret, cell writes, scroll and clearing pass.
// Depends on tcw_pkg; drives the screen store through its request structs.
module tcw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  tcw_pkg::item_t              item,
	input  logic [tcw_pkg::CELL_W-1:0]  fill_cell,
	input  logic [tcw_pkg::CELL_W-1:0]  rd_data,
	output logic                        busy,
	output logic                        done,
	output tcw_pkg::result_t            result,
	output tcw_pkg::ram_wr_t            wr,
	output tcw_pkg::ram_rd_t            rd
);
	import tcw_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CLEAR  = 7'b0000010,
		ST_RDWAIT = 7'b0000100,
		ST_PUT    = 7'b0001000,
		ST_CHECK  = 7'b0010000,
		ST_SCROLL = 7'b0100000,
		ST_FILL   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CELL_W-1:0] cell_q;
	logic              adv_q;
	logic              in_range_q;
	logic              done_q;
	result_t           result_q;

	logic [ROW_W-1:0]  rd_row;
	logic [COL_W-1:0]  rd_col;
	logic              rd_in_range;
	logic [CELL_W-1:0] blank_cell;
	logic [COL_W-1:0]  col_back;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Decode of the incoming word.
	assign rd_in_range = (item.read_row < ROW_OUT_W'(SCREEN_ROWS))
		&& (item.read_col < COL_OUT_W'(SCREEN_COLS));
	assign rd_row     = ROW_W'(item.read_row);
	assign rd_col     = COL_W'(item.read_col);
	assign blank_cell = make_cell(CH_BLANK, item.fg_color, item.bg_color);
	assign col_back   = (col_q != '0) ? COL_W'(col_q - 1'b1) : col_q;

	// Requests to the screen store.
	always_comb begin
		wr = '0;
		rd = '0;
		case (state_q)
			ST_IDLE: begin
				rd.en   = start && (item.command == CMD_READ);
				rd.addr = cell_addr(rd_row, rd_col);
			end
			ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = cnt_q[ADDR_W-1:0];
				wr.data = RESET_CELL;
			end
			ST_PUT: begin
				wr.en   = (row_q < ROW_W'(SCREEN_ROWS));
				wr.addr = cell_addr(row_q, col_q);
				wr.data = cell_q;
			end
			ST_SCROLL: begin
				rd.en   = (cnt_q < CNT_W'(MOVE_COUNT));
				rd.addr = ADDR_W'(cnt_q + CNT_W'(SHIFT));
				wr.en   = (cnt_q != '0);
				wr.addr = ADDR_W'(cnt_q - 1'b1);
				wr.data = rd_data;
			end
			ST_FILL: begin
				wr.en   = 1'b1;
				wr.addr = cnt_q[ADDR_W-1:0];
				wr.data = fill_cell;
			end
			default: begin
				wr = '0;
				rd = '0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			row_q      <= '0;
			col_q      <= '0;
			cnt_q      <= '0;
			cell_q     <= '0;
			adv_q      <= 1'b0;
			in_range_q <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (item.command == CMD_READ) begin
							in_range_q <= rd_in_range;
							state_q    <= ST_RDWAIT;
						end else begin
							case (item.char_code)
								CH_LF, CH_CR: begin
									row_q   <= ROW_W'(row_q + 1'b1);
									col_q   <= '0;
									state_q <= ST_CHECK;
								end
								CH_TAB: begin
									cell_q  <= blank_cell;
									adv_q   <= 1'b1;
									cnt_q   <= CNT_W'(TAB_STOP) - CNT_W'(col_q % TAB_STOP);
									state_q <= ST_PUT;
								end
								CH_BS: begin
									col_q   <= col_back;
									cell_q  <= blank_cell;
									adv_q   <= 1'b0;
									cnt_q   <= CNT_W'(1);
									state_q <= ST_PUT;
								end
								default: begin
									cell_q  <= make_cell(item.char_code, item.fg_color,
										item.bg_color);
									adv_q   <= 1'b1;
									cnt_q   <= CNT_W'(1);
									state_q <= ST_PUT;
								end
							endcase
						end
					end
				end
				ST_RDWAIT: begin
					result_q.caret_row  <= ROW_OUT_W'(row_q);
					result_q.caret_col  <= COL_OUT_W'(col_q);
					result_q.cell_value <= in_range_q ? rd_data : '0;
					done_q              <= 1'b1;
					state_q             <= ST_IDLE;
				end
				ST_PUT: begin
					// One cell per cycle; the caret steps and wraps after each, except on a backspace.
					if (adv_q) begin
						if (col_q == COL_W'(SCREEN_COLS - 1)) begin
							col_q <= '0;
							row_q <= ROW_W'(row_q + 1'b1);
						end else begin
							col_q <= COL_W'(col_q + 1'b1);
						end
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (row_q >= ROW_W'(SCREEN_ROWS)) begin
						row_q   <= ROW_W'(SCREEN_ROWS - 1);
						cnt_q   <= '0;
						state_q <= ST_SCROLL;
					end else begin
						result_q.caret_row  <= ROW_OUT_W'(row_q);
						result_q.caret_col  <= COL_OUT_W'(col_q);
						result_q.cell_value <= '0;
						done_q              <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				ST_SCROLL: begin
					// Read one row ahead, write the cell read in the previous cycle.
					if (cnt_q == CNT_W'(MOVE_COUNT)) begin
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						result_q.caret_row  <= ROW_OUT_W'(row_q);
						result_q.caret_col  <= COL_OUT_W'(col_q);
						result_q.cell_value <= '0;
						done_q              <= 1'b1;
						cnt_q               <= '0;
						state_q             <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/text_console_writer.sv -----
// Top level of the text console writer: scroll color registers and the two submodules.
// Depends on tcw_pkg, tcw_ctrl and tcw_screen_ram.
//
// The block takes one word while busy is low and start is high, and answers each word
// with exactly one result on result, marked by done for one cycle; the receiver cannot
// stall it. A newline and a carriage return write no cell; any other print writes its
// cells first, a tab one for each column up to the next tab stop. When the caret runs
// off the last row the screen scrolls: each cell below the top row moves up one row
// through the single read and single write port of the screen store, and the new
// bottom row is filled. After reset the store is cleared to blanks one cell per cycle,
// so busy stays high until every cell has been cleared.
module text_console_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tcw_pkg::item_t                item,
	output logic                          done,
	output tcw_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata
);
	import tcw_pkg::*;

	logic [COLOR_W-1:0] scroll_fg_q;
	logic [COLOR_W-1:0] scroll_bg_q;
	logic [CELL_W-1:0]  fill_cell;
	logic [CELL_W-1:0]  rd_data;
	ram_wr_t            wr;
	ram_rd_t            rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_fg_q <= RESET_FG;
			scroll_bg_q <= RESET_BG;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCROLL_FG: scroll_fg_q <= cfg_wdata;
				CFG_SCROLL_BG: scroll_bg_q <= cfg_wdata;
				default: begin
					scroll_fg_q <= scroll_fg_q;
				end
			endcase
		end
	end

	// Blank cell written into the new bottom row on a scroll.
	assign fill_cell = make_cell(CH_BLANK, scroll_fg_q, scroll_bg_q);

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.fill_cell (fill_cell),
		.rd_data   (rd_data),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.wr        (wr),
		.rd        (rd)
	);

	tcw_screen_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

endmodule
